// ===== src/cnls_pkg.sv =====
// Shared types, opcodes and the microcode table of the character LCD nibble sequencer.
// No dependencies; every other file but cnls_if imports this package.
package cnls_pkg;

  // request opcodes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_GLYPH  = 3'd5;

  // nibble source select
  localparam logic [1:0] NSRC_CONST = 2'd0;
  localparam logic [1:0] NSRC_HI    = 2'd1;
  localparam logic [1:0] NSRC_LO    = 2'd2;

  // RS handling
  localparam logic [1:0] RS_KEEP = 2'd0;  // drive stored level, leave it
  localparam logic [1:0] RS_CMD  = 2'd1;  // force command level
  localparam logic [1:0] RS_REQ  = 2'd2;  // level taken from the request

  localparam int PC_W = 5;

  // program entry points
  localparam logic [PC_W-1:0] PC_INIT     = 5'd0;
  localparam logic [PC_W-1:0] PC_BYTE     = 5'd25;
  localparam logic [PC_W-1:0] PC_CLR_TAIL = 5'd29;

  localparam logic [7:0] BYTE_CLEAR = 8'h01;
  localparam logic [7:0] CURSOR_BIT = 8'h80;
  localparam logic [7:0] GLYPH_BIT  = 8'h40;

  typedef struct packed {
    logic [1:0]      nsrc;
    logic [3:0]      nib;
    logic            en;
    logic [6:0]      hold;
    logic [1:0]      rs_op;
    logic            jmp_clr;  // jump to target when request is a clear
    logic [PC_W-1:0] target;
    logic            eop;      // last step of the program
  } ucode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic [1:0] row;
    logic [2:0] glyph_slot;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] nibble;
    logic [6:0] hold_ms;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic start;    // request accepted that runs a program
    logic advance;  // current control word issues a beat
  } seq_ctl_t;

  function automatic ucode_t uw(logic [1:0] nsrc, logic [3:0] nib, logic en,
                                logic [6:0] hold, logic [1:0] rs_op, logic eop);
    ucode_t w;
    w.nsrc    = nsrc;
    w.nib     = nib;
    w.en      = en;
    w.hold    = hold;
    w.rs_op   = rs_op;
    w.jmp_clr = 1'b0;
    w.target  = '0;
    w.eop     = eop;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd1, RS_KEEP, 1'b1);
    unique case (pc)
      // power-up wait, then three raw 0x3 nibbles and the switch to 4-bit
      5'd0:  w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd95,  RS_KEEP, 1'b0);
      5'd1:  w = uw(NSRC_CONST, 4'h3, 1'b1, 7'd1,   RS_KEEP, 1'b0);
      5'd2:  w = uw(NSRC_CONST, 4'h3, 1'b0, 7'd46,  RS_KEEP, 1'b0);
      5'd3:  w = uw(NSRC_CONST, 4'h3, 1'b1, 7'd1,   RS_KEEP, 1'b0);
      5'd4:  w = uw(NSRC_CONST, 4'h3, 1'b0, 7'd46,  RS_KEEP, 1'b0);
      5'd5:  w = uw(NSRC_CONST, 4'h3, 1'b1, 7'd1,   RS_KEEP, 1'b0);
      5'd6:  w = uw(NSRC_CONST, 4'h3, 1'b0, 7'd46,  RS_KEEP, 1'b0);
      5'd7:  w = uw(NSRC_CONST, 4'h2, 1'b1, 7'd1,   RS_KEEP, 1'b0);
      5'd8:  w = uw(NSRC_CONST, 4'h2, 1'b0, 7'd101, RS_KEEP, 1'b0);
      // function set 0x28
      5'd9:  w = uw(NSRC_CONST, 4'h2, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd10: w = uw(NSRC_CONST, 4'h2, 1'b0, 7'd1,   RS_CMD,  1'b0);
      5'd11: w = uw(NSRC_CONST, 4'h8, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd12: w = uw(NSRC_CONST, 4'h8, 1'b0, 7'd1,   RS_CMD,  1'b0);
      // display on 0x0C
      5'd13: w = uw(NSRC_CONST, 4'h0, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd14: w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd1,   RS_CMD,  1'b0);
      5'd15: w = uw(NSRC_CONST, 4'hC, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd16: w = uw(NSRC_CONST, 4'hC, 1'b0, 7'd46,  RS_CMD,  1'b0);
      // clear 0x01
      5'd17: w = uw(NSRC_CONST, 4'h0, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd18: w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd1,   RS_CMD,  1'b0);
      5'd19: w = uw(NSRC_CONST, 4'h1, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd20: w = uw(NSRC_CONST, 4'h1, 1'b0, 7'd4,   RS_CMD,  1'b0);
      // entry mode 0x06
      5'd21: w = uw(NSRC_CONST, 4'h0, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd22: w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd1,   RS_CMD,  1'b0);
      5'd23: w = uw(NSRC_CONST, 4'h6, 1'b1, 7'd1,   RS_CMD,  1'b0);
      5'd24: w = uw(NSRC_CONST, 4'h6, 1'b0, 7'd1,   RS_CMD,  1'b1);
      // generic byte from the byte register
      5'd25: w = uw(NSRC_HI,    4'h0, 1'b1, 7'd1,   RS_REQ,  1'b0);
      5'd26: w = uw(NSRC_HI,    4'h0, 1'b0, 7'd1,   RS_REQ,  1'b0);
      5'd27: begin
        w = uw(NSRC_LO, 4'h0, 1'b1, 7'd1, RS_REQ, 1'b0);
        w.jmp_clr = 1'b1;
        w.target  = PC_CLR_TAIL;
      end
      5'd28: w = uw(NSRC_LO,    4'h0, 1'b0, 7'd1,   RS_REQ,  1'b1);
      // clear tail: 3 ms extra settle
      5'd29: w = uw(NSRC_LO,    4'h0, 1'b0, 7'd4,   RS_REQ,  1'b1);
      default: w = uw(NSRC_CONST, 4'h0, 1'b0, 7'd1, RS_KEEP, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      2'd3: b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/cnls_if.sv =====
// Valid/ready channel interfaces for the request and pin-state beats.
// Depends on nothing.
interface cnls_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] byte_value;
  logic [5:0] column;
  logic [1:0] row;
  logic [2:0] glyph_slot;

  modport source (output valid, opcode, byte_value, column, row, glyph_slot, input ready);
  modport sink   (input valid, opcode, byte_value, column, row, glyph_slot, output ready);
endinterface

interface cnls_pin_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       enable;
  logic [3:0] nibble;
  logic [6:0] hold_ms;
  logic       last;

  modport source (output valid, reg_select, enable, nibble, hold_ms, last, input ready);
  modport sink   (input valid, reg_select, enable, nibble, hold_ms, last, output ready);
endinterface

// ===== src/cnls_ucode_rom.sv =====
// Microcode store: maps the step counter to one control word.
// Depends on cnls_pkg.
module cnls_ucode_rom
  import cnls_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output ucode_t          word
);

  assign word = ucode_rom(pc);

endmodule

// ===== src/cnls_seq.sv =====
// Step counter with program entry, conditional jump and end-of-program detect.
// Depends on cnls_pkg.
module cnls_seq
  import cnls_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  seq_ctl_t        ctl,
  input  logic [PC_W-1:0] entry_pc,
  input  logic            entry_clr,
  input  ucode_t          word,
  output logic [PC_W-1:0] pc,
  output logic            busy
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            clr_r, clr_nxt;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    clr_nxt  = clr_r;
    if (ctl.start) begin
      pc_nxt   = entry_pc;
      busy_nxt = 1'b1;
      clr_nxt  = entry_clr;
    end else if (ctl.advance) begin
      if (word.eop) begin
        busy_nxt = 1'b0;
      end else if (word.jmp_clr && clr_r) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_INIT;
      busy_r <= 1'b0;
      clr_r  <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
      clr_r  <= clr_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = busy_r;

endmodule

// ===== src/cnls_dp.sv =====
// Datapath: request byte register, stored RS level and the output beat register.
// Depends on cnls_pkg.
module cnls_dp
  import cnls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  seq_ctl_t ctl,
  input  req_t     req,
  input  ucode_t   word,
  input  logic     out_ready,
  output logic     room,
  output logic     out_valid,
  output beat_t    out_beat
);

  logic [7:0] byte_r, byte_nxt;
  logic       rs_req_r;
  logic       rs_level_r;
  logic       out_valid_r, out_valid_nxt;
  beat_t      out_r;
  logic       cur_rs;
  logic [3:0] cur_nib;

  // byte sent by the generic byte routine
  always_comb begin
    case (req.opcode) inside
      OP_CMD, OP_DATA: byte_nxt = req.byte_value;
      OP_CURSOR: byte_nxt = CURSOR_BIT | ({2'b00, req.column} + row_base(req.row));
      OP_CLEAR:  byte_nxt = BYTE_CLEAR;
      OP_GLYPH:  byte_nxt = GLYPH_BIT | {2'b00, req.glyph_slot, 3'b000};
      default:   byte_nxt = 8'h00;
    endcase
  end

  always_comb begin
    unique case (word.rs_op)
      RS_KEEP: cur_rs = rs_level_r;
      RS_CMD:  cur_rs = 1'b0;
      RS_REQ:  cur_rs = rs_req_r;
      default: cur_rs = rs_level_r;
    endcase
    unique case (word.nsrc)
      NSRC_CONST: cur_nib = word.nib;
      NSRC_HI:    cur_nib = byte_r[7:4];
      NSRC_LO:    cur_nib = byte_r[3:0];
      default:    cur_nib = word.nib;
    endcase
  end

  assign room = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_level_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.advance) begin
        rs_level_r <= cur_rs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      byte_r   <= byte_nxt;
      rs_req_r <= (req.opcode == OP_DATA);
    end
    if (ctl.advance) begin
      out_r.reg_select <= cur_rs;
      out_r.enable     <= word.en;
      out_r.nibble     <= cur_nib;
      out_r.hold_ms    <= word.hold;
      out_r.last       <= word.eop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

// ===== src/char_lcd_nibble_sequencer_unit.sv =====
// Character LCD 4-bit bus sequencer, top level. Depends on cnls_pkg, cnls_if,
// cnls_ucode_rom, cnls_seq and cnls_dp.
//
// Each request on in_bus (init, command byte, data byte, set cursor, clear,
// glyph address) is turned into a list of timed pin-state beats on out_bus:
// RS, E, D7..D4 and how long (ms) the levels are held; the last beat of a
// request has last set. A byte goes high nibble first, each nibble as an
// E-high beat (1 ms) then an E-low beat (1 ms plus any settle time). Init
// gives 25 beats, every other request 4; opcodes 6 and 7 are taken and
// dropped with no beats. Work is paced by a step counter walking a 30-word
// microcode table, one control word and one beat per cycle when the sink
// takes beats without stall; in_bus.ready stays low while a program runs.
// The next request is taken as soon as the last beat is in the output
// register. RS set by a command or data byte is kept for later requests;
// the raw init nibbles use the kept level.
module char_lcd_nibble_sequencer_unit
  import cnls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cnls_req_if.sink   in_bus,
  cnls_pin_if.source out_bus
);

  logic            busy;
  logic            room;
  logic [PC_W-1:0] pc;
  ucode_t          word;
  seq_ctl_t        ctl;
  req_t            req;
  logic            op_valid;
  logic [PC_W-1:0] entry_pc;
  logic            entry_clr;
  logic            out_valid;
  beat_t           out_beat;

  assign in_bus.ready = !busy;

  assign req.opcode     = in_bus.opcode;
  assign req.byte_value = in_bus.byte_value;
  assign req.column     = in_bus.column;
  assign req.row        = in_bus.row;
  assign req.glyph_slot = in_bus.glyph_slot;

  // opcodes past glyph address run no program
  assign op_valid  = (in_bus.opcode <= OP_GLYPH);
  assign entry_pc  = (in_bus.opcode == OP_INIT) ? PC_INIT : PC_BYTE;
  assign entry_clr = (in_bus.opcode == OP_CLEAR);

  assign ctl.start   = in_bus.valid && in_bus.ready && op_valid;
  assign ctl.advance = busy && room;

  cnls_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  cnls_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .entry_pc  (entry_pc),
    .entry_clr (entry_clr),
    .word      (word),
    .pc        (pc),
    .busy      (busy)
  );

  cnls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .req       (req),
    .word      (word),
    .out_ready (out_bus.ready),
    .room      (room),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  assign out_bus.valid      = out_valid;
  assign out_bus.reg_select = out_beat.reg_select;
  assign out_bus.enable     = out_beat.enable;
  assign out_bus.nibble     = out_beat.nibble;
  assign out_bus.hold_ms    = out_beat.hold_ms;
  assign out_bus.last       = out_beat.last;

`ifndef SYNTHESIS
  // strobe beats are always the short 1 ms pulse
  a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.enable |-> out_beat.hold_ms == 7'd1)
    else $error("E-high beat with hold other than 1 ms");

  // issuing the end-of-program word frees the block for a new request
  a_eop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.advance && word.eop |=> !busy && out_valid && out_beat.last)
    else $error("program end did not release the sequencer");

  // a beat marked last is never followed by more beats of the same program
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.last && $past(ctl.advance) |-> !busy)
    else $error("sequencer still running after last beat");
`endif

endmodule
